/* hdl/fpng_pkg.sv */
// Shared types and constants for the frame peak-normalizing gain block.
// No dependencies.
package fpng_pkg;

  localparam int DEFAULT_MAX_FRAME = 64;

  localparam int SAMPLE_W  = 16;
  localparam int TARGET_W  = 15;
  localparam int GAIN_W    = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;

  localparam logic [TARGET_W-1:0] TARGET_RESET   = 15'd13106;
  localparam logic [GAIN_W-1:0]   MAX_GAIN_RESET = 18'd163840;
  localparam logic [GAIN_W-1:0]   ONE_Q16        = 18'd65536;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

  // register map
  localparam cfg_idx_t REG_TARGET_PEAK = 2'd0;
  localparam cfg_idx_t REG_MAX_GAIN    = 2'd1;

endpackage

/* hdl/frame_peak_normalizing_gain.sv */
// Frame peak-normalizing gain: top level with frame store, serial divider
// and gain multiplier pipeline. Depends on fpng_pkg.
// Sequence: the last sample of a frame starts a serial divide, then a clamp
// state and a 3-stage read/multiply/round pipe; results then follow one a
// cycle with no stalls. The block takes no new samples while busy; busy
// clears at the edge that takes the last result. Config waits for idle.
// Reset (rst, synchronous, active high) empties the frame, clears the peak and
// restores register defaults; the frame store itself is not cleared.
module frame_peak_normalizing_gain #(
  parameter int MAX_FRAME = fpng_pkg::DEFAULT_MAX_FRAME
) (
  input  logic                     clk,
  input  logic                     rst,
  // sample input, command style
  input  logic                     start,
  output logic                     busy,
  input  logic signed [15:0]       sample_in,
  input  logic                     frame_end,
  // results, one cycle each
  output logic                     result_valid,
  output logic signed [15:0]       sample_out,
  output logic                     last_out,
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  fpng_pkg::cfg_idx_t       cfg_index,
  input  fpng_pkg::cfg_dat_t       cfg_data
);
  import fpng_pkg::*;

  localparam int AW  = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int FCW = $clog2(MAX_FRAME + 1);
  localparam int QW  = TARGET_W + 16;       // dividend / quotient width
  localparam int SW  = $clog2(QW);          // division step counter
  localparam int PW  = 16 + GAIN_W;         // product width

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_GAIN, S_EMIT} state_t;

  state_t state;

  // configuration registers
  logic [TARGET_W-1:0] target_peak;
  logic [GAIN_W-1:0]   max_gain_q16;

  // frame bookkeeping
  logic [FCW-1:0] fill_count;
  logic [FCW-1:0] frame_len;
  logic [15:0]    peak_magnitude;

  // divider
  logic [QW-1:0]  dvd;          // dividend in, quotient out
  logic [16:0]    rem;
  logic [SW-1:0]  step;

  logic [GAIN_W-1:0] gain;

  // emit pipeline
  logic [FCW-1:0] rd_ptr;
  logic           v1, v2;
  logic           last1, last2;
  logic           neg2;
  logic [PW-1:0]  prod;

  // frame store
  logic [15:0] frame_store [MAX_FRAME];
  logic [15:0] rd_data;

  // ---- accept path ----
  logic           accept;
  logic [15:0]    in_mag;
  logic [FCW-1:0] fill_next;
  logic           frame_done;
  logic [15:0]    peak_next;

  // register writes only between frames' computations
  assign cfg_ready = !busy;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  // |-32768| = 32768 still fits 16 unsigned bits
  assign in_mag     = sample_in[15] ? 16'(-sample_in) : 16'(sample_in);
  assign fill_next  = fill_count + FCW'(1);
  assign frame_done = frame_end || (fill_next == FCW'(MAX_FRAME));
  assign peak_next  = (in_mag > peak_magnitude) ? in_mag : peak_magnitude;

  // ---- divider step: restoring, one quotient bit per cycle ----
  logic [16:0] rem_sh;
  logic [17:0] trial;
  logic        qbit;

  assign rem_sh = {rem[15:0], dvd[QW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b0, peak_magnitude};
  assign qbit   = !trial[17];

  // ---- gain clamp: floor of 1.0 first, then the max_gain ceiling; a zero peak takes max_gain ----
  logic [QW-1:0]     q_floor;
  logic [GAIN_W-1:0] gain_next;

  assign q_floor = (dvd < QW'(ONE_Q16)) ? QW'(ONE_Q16) : dvd;
  always_comb begin
    if (peak_magnitude == 16'd0) begin
      gain_next = max_gain_q16;
    end else if (q_floor > QW'(max_gain_q16)) begin
      gain_next = max_gain_q16;
    end else begin
      gain_next = q_floor[GAIN_W-1:0];
    end
  end

  // ---- multiply stage input ----
  logic        neg1;
  logic [15:0] mag1;

  assign neg1 = rd_data[15];
  assign mag1 = neg1 ? 16'(-rd_data) : rd_data;

  // ---- round half away from zero, saturate ----
  logic [PW:0]  prod_rnd;
  logic [18:0]  r_mag;
  logic [15:0]  r_sat;
  logic [15:0]  out_word;

  assign prod_rnd = {1'b0, prod} + (PW+1)'(32768);
  assign r_mag    = prod_rnd[PW:16];
  always_comb begin
    if (neg2) begin
      r_sat    = (r_mag > 19'd32768) ? 16'd32768 : r_mag[15:0];
      out_word = 16'(-r_sat);
    end else begin
      r_sat    = (r_mag > 19'd32767) ? 16'd32767 : r_mag[15:0];
      out_word = r_sat;
    end
  end

  // ---- frame store: write on accept, registered read during emit ----
  always_ff @(posedge clk) begin
    if (accept) begin
      frame_store[fill_count[AW-1:0]] <= sample_in;
    end
    rd_data <= frame_store[rd_ptr[AW-1:0]];
  end

  // ---- sequencer, registers and outputs ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      target_peak    <= TARGET_RESET;
      max_gain_q16   <= MAX_GAIN_RESET;
      fill_count     <= '0;
      frame_len      <= '0;
      peak_magnitude <= '0;
      step           <= '0;
      rd_ptr         <= '0;
      v1             <= 1'b0;
      v2             <= 1'b0;
      result_valid   <= 1'b0;
      last_out       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TARGET_PEAK: target_peak  <= cfg_data[TARGET_W-1:0];
          REG_MAX_GAIN:    max_gain_q16 <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      // output register, fed by the multiply stage
      result_valid <= v2;
      last_out     <= v2 && last2;
      v2           <= 1'b0;
      v1           <= 1'b0;

      if (v1) begin
        v2    <= 1'b1;
        last2 <= last1;
        neg2  <= neg1;
        prod  <= PW'(mag1) * PW'(gain);
      end
      if (v2) begin
        sample_out <= out_word;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            peak_magnitude <= peak_next;
            if (frame_done) begin
              frame_len  <= fill_next;
              fill_count <= '0;
              dvd        <= {target_peak, 16'd0};
              rem        <= '0;
              step       <= '0;
              state      <= S_DIV;
            end else begin
              fill_count <= fill_next;
            end
          end
        end
        S_DIV: begin
          // peak 0 is caught in the clamp; quotient is then unused
          rem  <= qbit ? trial[16:0] : rem_sh;
          dvd  <= {dvd[QW-2:0], qbit};
          step <= step + SW'(1);
          if (step == SW'(QW - 1)) begin
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          gain           <= gain_next;
          peak_magnitude <= '0;
          rd_ptr         <= '0;
          state          <= S_EMIT;
        end
        S_EMIT: begin
          if (rd_ptr != frame_len) begin
            v1     <= 1'b1;
            last1  <= (rd_ptr + FCW'(1)) == frame_len;
            rd_ptr <= rd_ptr + FCW'(1);
          end else if (!v1 && !v2) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no read or multiply in flight once the block takes samples again
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (!v1 && !v2))
    else $error("emit pipeline not drained while idle");

  // the open frame never holds a full store while idle
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (fill_count < FCW'(MAX_FRAME)))
    else $error("fill count out of range");

  // a sample that closes the frame starts the gain computation
  a_end_starts_div: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |=> (state == S_DIV))
    else $error("frame end did not start division");

  // every result left the multiply stage in the previous cycle
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(v2))
    else $error("result without a product behind it");

  // the last flag only marks a valid result, and results stop after it
  a_last_marks: assert property (@(posedge clk) disable iff (rst)
    last_out |-> (result_valid && !v2))
    else $error("last flag misplaced");
`endif

endmodule

/* tb/tb_frame_peak_normalizing_gain.sv */
// Self-checking testbench for frame_peak_normalizing_gain: frame gain, rounding,
// frame-full close and register writes, checked against a built-in predictor.
// Depends on fpng_pkg and the frame_peak_normalizing_gain RTL.

// Predicts the gained output stream from accepted samples and register writes,
// and checks each output transaction against the oldest predicted sample.
class normalized_frames;
  typedef struct packed {
    logic signed [15:0] smp;
    logic               last;
  } gained_t;

  localparam int FRAME_CAP = fpng_pkg::DEFAULT_MAX_FRAME;

  logic [fpng_pkg::TARGET_W-1:0] target_peak;
  logic [fpng_pkg::GAIN_W-1:0]   gain_cap;
  logic signed [15:0]            held [FRAME_CAP];
  logic [16:0]                   peak;
  int                            held_cnt;
  gained_t                       due_samples [$];
  int                            fails;

  function new();
    target_peak = fpng_pkg::TARGET_RESET;
    gain_cap    = fpng_pkg::MAX_GAIN_RESET;
    peak        = '0;
    held_cnt    = 0;
    fails       = 0;
  endfunction

  // Out-of-range indexes are dropped; data wider than a register is truncated.
  function void set_reg(fpng_pkg::cfg_idx_t idx, fpng_pkg::cfg_dat_t d);
    case (idx)
      fpng_pkg::REG_TARGET_PEAK: target_peak = d[fpng_pkg::TARGET_W-1:0];
      fpng_pkg::REG_MAX_GAIN:    gain_cap    = d[fpng_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // Q2.16 gain: target/peak, floored at 1.0, then capped (cap wins if below 1.0).
  function logic [fpng_pkg::GAIN_W-1:0] gain_for_peak();
    longint unsigned q;
    if (peak == 0) return gain_cap;
    q = (longint'(target_peak) << 16) / longint'(peak);
    if (q < fpng_pkg::ONE_Q16) q = fpng_pkg::ONE_Q16;
    if (q > gain_cap) q = gain_cap;
    return fpng_pkg::GAIN_W'(q);
  endfunction

  // Magnitude times gain, round half away from zero, saturate to int16.
  function logic signed [15:0] scale_sample(logic signed [15:0] s,
                                            logic [fpng_pkg::GAIN_W-1:0] g);
    longint unsigned mag;
    longint unsigned r;
    mag = (s < 0) ? longint'(-int'(s)) : longint'(s);
    r = (mag * g + 64'd32768) >> 16;
    if (s < 0) begin
      if (r > 32768) r = 32768;
      return 16'(-int'(r));
    end
    if (r > 32767) r = 32767;
    return 16'(r);
  endfunction

  function void note_sample(logic signed [15:0] s, logic fe);
    logic [16:0]                 mag;
    logic [fpng_pkg::GAIN_W-1:0] g;
    mag = (s < 0) ? 17'(-int'(s)) : 17'(s);
    if (held_cnt < FRAME_CAP) begin
      held[held_cnt] = s;
      held_cnt++;
    end
    if (mag > peak) peak = mag;
    if (fe || held_cnt == FRAME_CAP) begin
      g = gain_for_peak();
      for (int i = 0; i < held_cnt; i++)
        due_samples.push_back('{smp: scale_sample(held[i], g), last: (i == held_cnt - 1)});
      held_cnt = 0;
      peak = '0;
    end
  endfunction

  function void check_output(logic signed [15:0] s, logic last);
    gained_t want;
    if (due_samples.size() == 0) begin
      $display("%0t: unexpected output sample_out=%0d last_out=%0b", $time, s, last);
      fails++;
      return;
    end
    want = due_samples.pop_front();
    if (s !== want.smp) begin
      $display("%0t: sample_out expected %0d got %0d", $time, want.smp, s);
      fails++;
    end
    if (last !== want.last) begin
      $display("%0t: last_out expected %0b got %0b", $time, want.last, last);
      fails++;
    end
  endfunction

  function int pending();
    return due_samples.size();
  endfunction
endclass

module tb_frame_peak_normalizing_gain;
  import fpng_pkg::*;

  localparam int FRAME_CAP   = DEFAULT_MAX_FRAME;
  // Longest legal quiet stretch is the divide/clamp time plus the longest
  // sender gap or the settle time before register writes.
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYC  = 12;

  // Indexes past the register map; writes there must be dropped.
  localparam cfg_idx_t REG_SPARE_2 = 2'd2;
  localparam cfg_idx_t REG_SPARE_3 = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] sample_in = '0;
  logic               frame_end = 1'b0;
  logic               result_valid;
  logic signed [15:0] sample_out;
  logic               last_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index = '0;
  cfg_dat_t           cfg_data = '0;

  normalized_frames frames;
  bit               idle_en = 1'b0;
  int               quiet_cycles = 0;

  frame_peak_normalizing_gain uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_in    (sample_in),
    .frame_end    (frame_end),
    .result_valid (result_valid),
    .sample_out   (sample_out),
    .last_out     (last_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: results cannot be stalled, so every strobed cycle is a
  // transaction. Values read at the edge are the ones the cycle carried.
  always @(posedge clk) begin
    if (!rst && result_valid) frames.check_output(sample_out, last_out);
  end

  // Watchdog: any input, output or register transaction clears the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // One sample transaction. start stays high on return so a back-to-back
  // sample needs no toggle; an idle burst drops it first.
  task automatic push_sample(input logic signed [15:0] s, input logic fe);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start     <= 1'b1;
    sample_in <= s;
    frame_end <= fe;
    do @(posedge clk); while (busy);
    frames.note_sample(s, fe);
  endtask

  // Mix of full-range, small (high gain), extreme and mid-size samples.
  function automatic logic signed [15:0] pick_sample();
    int v;
    case ($urandom_range(0, 5))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: v = int'($urandom_range(0, 127)) - 64;
      2: begin
        case ($urandom_range(0, 4))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      default: v = int'($urandom_range(0, 4095)) - 2048;
    endcase
    return 16'(v);
  endfunction

  // A full-length frame closes on its own; frame_end on its last sample is
  // then optional.
  task automatic send_frame(input int len, input logic end_on_full);
    for (int i = 0; i < len; i++)
      push_sample(pick_sample(),
                  (i == len - 1) ? (len < FRAME_CAP || end_on_full) : 1'b0);
  endtask

  // Drain all pending output, then wait out the settle time before register writes
  // (busy clears at the edge that takes the last output).
  task automatic settle();
    start <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_dat_t d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    frames.set_reg(idx, d);
  endtask

  // Both registers plus a stray write to an unmapped index. Spare upper data
  // bits on the target write are random to check truncation.
  task automatic load_regs(input logic [TARGET_W-1:0] tp, input logic [GAIN_W-1:0] mg);
    settle();
    write_reg(REG_TARGET_PEAK, {3'($urandom_range(0, 7)), tp});
    write_reg(REG_MAX_GAIN, mg);
    write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 18'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [TARGET_W-1:0] tp;
    logic [GAIN_W-1:0]   mg;
    int                  n;
    int                  len;

    frames = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    idle_en = 1'b1;

    // --- directed frames, reset register values (target 13106, gain 2.5) ---
    // full-scale peak: computed gain below 1.0, floored to unity
    push_sample(16'sd32767, 1'b1);
    // most negative sample sets a 32768 peak
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd1, 1'b0);
    push_sample(-16'sd1, 1'b1);
    // all-zero frame: zero peak takes the gain cap
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd0, 1'b1);
    // tiny peak: capped at 2.5, +/-3 land on exact halves and round outward
    push_sample(16'sd100, 1'b0);
    push_sample(-16'sd3, 1'b0);
    push_sample(16'sd3, 1'b0);
    push_sample(-16'sd100, 1'b1);

    // zero target: gain floors at 1.0 under the widest cap
    load_regs(15'd0, 18'd262143);
    push_sample(16'sd1000, 1'b0);
    push_sample(-16'sd7, 1'b1);

    // zero cap: everything is scaled to zero
    load_regs(15'd32767, 18'd0);
    push_sample(16'sd12345, 1'b0);
    push_sample(-16'sd32768, 1'b1);

    // cap of 0.5 attenuates; 32767 and 3 land on halves
    load_regs(15'd1, 18'd32768);
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sd32767, 1'b0);
    push_sample(16'sd3, 1'b1);

    // --- random frames over several register settings ---
    // The first phase opens with a frame-full close; the last phase runs
    // with no sender gaps.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          tp = 15'd32767;
          mg = 18'd262143;
        end
        1: begin
          tp = 15'd1;
          mg = ONE_Q16;
        end
        4: begin
          tp = TARGET_RESET;
          mg = MAX_GAIN_RESET;
        end
        default: begin
          tp = 15'($urandom_range(0, 32767));
          mg = 18'($urandom_range(0, 262143));
        end
      endcase
      load_regs(tp, mg);
      n = 0;
      while (n < 10) begin
        // some frames run with no gaps at all
        idle_en = (ph != 5) && ($urandom_range(0, 2) != 0);
        if ((n == 0 && ph == 0) || $urandom_range(0, 19) == 0) len = FRAME_CAP;
        else len = $urandom_range(1, 12);
        send_frame(len, 1'($urandom_range(0, 1)));
        n += len;
      end
    end

    // Drain, then watch a little longer for stray output.
    start <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (frames.fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
